[rtl/core/cma_pkg.sv]
// Shared constants for the centered moving average block.
package cma_pkg;

    localparam int RADIUS_BITS      = 6;
    localparam int DIVISOR_BITS     = RADIUS_BITS + 1;
    localparam int DEF_MAX_RADIUS   = 63;
    localparam int DEF_SAMPLE_BITS  = 16;

endpackage

[rtl/core/cma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/cma_div.sv]
// Restoring divider, one quotient bit per cycle.
module cma_div
    import cma_pkg::*;
#(
    parameter int DVD_W = 23
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [DVD_W-1:0]        i_dividend,
    input  logic [DIVISOR_BITS-1:0] i_divisor,
    output logic                    o_busy,
    output logic [DVD_W-1:0]        o_quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_busy, n_busy;
    logic [DVD_W-1:0]        r_quo, n_quo;
    logic [DIVISOR_BITS-1:0] r_rem, n_rem;
    logic [DIVISOR_BITS-1:0] r_dvs, n_dvs;
    logic [DIVISOR_BITS:0]   trial;
    logic [DIVISOR_BITS:0]   diff;

    always_comb begin
        trial  = {r_rem, r_quo[DVD_W-1]};
        diff   = trial - {1'b0, r_dvs};
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DVD_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // shift one dividend bit in, subtract where it fits
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = diff[DIVISOR_BITS-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIVISOR_BITS-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

[rtl/core/centered_moving_average.sv]
// Top level of the centered moving average (boxcar) filter.
//
// Centered moving average over a stream of unsigned samples. Each accepted
// word carries one sample; tlast marks the last sample of a sequence. For each
// centre index the block returns the truncated mean of the 2k+1 samples around
// it, or -1 (all ones) where the window runs past either end of the sequence,
// so results trail the input by k samples. The last sample of a sequence also
// flushes the trailing -1 results (tlast is set on the final one) and restarts
// the sequence, so every sequence yields as many results as it had samples.
// k is the radius register, clamped to MAX_RADIUS; any write of it restarts
// the sequence. A sample whose window is complete waits on the bit-serial
// divider that divides the window sum by 2k+1, and no new sample is taken
// until its average has gone to the output register; a sample that yields
// -1 or nothing skips the divider. The delay line sits in a RAM with no
// reset; no clearing pass is needed.
module centered_moving_average
    import cma_pkg::*;
#(
    parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: radius
    input  logic                              i_cfg_we,
    input  logic [RADIUS_BITS-1:0]            i_cfg_wdata,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  i_s_axis_tdata,   // sample
    input  logic                              i_s_axis_tlast,   // is_last
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [((SAMPLE_BITS+8)/8)*8-1:0]  o_m_axis_tdata,   // average
    output logic                              o_m_axis_tlast    // last_result
);

    localparam int AW     = $clog2(2 * MAX_RADIUS + 1);
    localparam int DEPTH  = 2 ** AW;
    localparam int SW     = SAMPLE_BITS + AW;
    localparam int AVG_W  = SAMPLE_BITS + 1;
    localparam int ODW    = ((SAMPLE_BITS + 8) / 8) * 8;
    localparam int SEEN_W = RADIUS_BITS + 1;

    localparam logic [RADIUS_BITS-1:0] MAX_K = RADIUS_BITS'(MAX_RADIUS);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [RADIUS_BITS-1:0] r_radius, n_radius;
    logic [SW-1:0]          r_sum, n_sum;
    logic [AW-1:0]          r_wp, n_wp;
    logic [AW-1:0]          r_raddr, n_raddr;
    logic [SEEN_W-1:0]      r_seen, n_seen;
    logic [RADIUS_BITS-1:0] r_flush, n_flush;
    logic                   r_last, n_last;
    logic                   r_ovalid, n_ovalid;
    logic [AVG_W-1:0]       r_avg, n_avg;
    logic                   r_olast, n_olast;

    logic [RADIUS_BITS-1:0]  k;
    logic [SEEN_W-1:0]       two_k;
    logic [DIVISOR_BITS-1:0] divisor;
    logic [SEEN_W-1:0]       seq_len;
    logic [SAMPLE_BITS-1:0]  sample;
    logic [SW-1:0]           sum_plus;
    logic                    out_free;
    logic                    accept;
    logic                    win_full;
    logic                    div_start;
    logic                    div_busy;
    logic [SW-1:0]           div_quo;
    logic                    ram_re;
    logic [SAMPLE_BITS-1:0]  ram_rdata;

    assign k        = (r_radius > MAX_K) ? MAX_K : r_radius;
    assign two_k    = {k, 1'b0};
    assign divisor  = {k, 1'b1};
    assign seq_len  = r_seen + 1'b1;
    assign sample   = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign sum_plus = r_sum + SW'(sample);
    assign out_free = !r_ovalid || i_m_axis_tready;
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign win_full = (r_seen >= two_k);
    assign div_start = accept && win_full;
    assign ram_re   = (r_state == S_DIV);

    assign o_s_axis_tready = (r_state == S_IDLE) && out_free && !i_cfg_we;

    always_comb begin
        n_state  = r_state;
        n_radius = r_radius;
        n_sum    = r_sum;
        n_wp     = r_wp;
        n_raddr  = r_raddr;
        n_seen   = r_seen;
        n_flush  = r_flush;
        n_last   = r_last;
        n_avg    = r_avg;
        n_olast  = r_olast;
        n_ovalid = r_ovalid;

        // drop the word once the sink has taken it
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        if (i_cfg_we) begin
            // new radius: restart the sequence, drop anything pending
            n_radius = i_cfg_wdata;
            n_sum    = '0;
            n_wp     = '0;
            n_seen   = '0;
            n_flush  = '0;
            n_ovalid = 1'b0;
            n_state  = S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        n_wp    = i_s_axis_tlast ? '0 : r_wp + 1'b1;
                        n_raddr = r_wp - AW'(two_k);
                        n_last  = i_s_axis_tlast;
                        n_flush = '0;
                        if (i_s_axis_tlast) begin
                            n_flush = (seq_len < {1'b0, k}) ?
                                      seq_len[RADIUS_BITS-1:0] : k;
                        end
                        if (i_s_axis_tlast) begin
                            n_seen = '0;
                        end else if (r_seen < two_k) begin
                            n_seen = r_seen + 1'b1;
                        end
                        if (win_full) begin
                            // hold the sum until the oldest sample is read back
                            n_sum   = sum_plus;
                            n_state = S_DIV;
                        end else begin
                            n_sum = i_s_axis_tlast ? '0 : sum_plus;
                            if (r_seen >= {1'b0, k}) begin
                                n_avg    = '1;
                                n_olast  = 1'b0;
                                n_ovalid = 1'b1;
                            end
                            n_state = i_s_axis_tlast ? S_FLUSH : S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    if (!div_busy && out_free) begin
                        n_avg    = {1'b0, div_quo[SAMPLE_BITS-1:0]};
                        n_olast  = r_last && (r_flush == '0);
                        n_ovalid = 1'b1;
                        n_sum    = r_last ? '0 : r_sum - SW'(ram_rdata);
                        n_state  = (r_flush != '0) ? S_FLUSH : S_IDLE;
                    end
                end
                S_FLUSH: begin
                    // trailing -1 results after the last sample
                    if (out_free) begin
                        n_avg    = '1;
                        n_olast  = (r_flush == RADIUS_BITS'(1));
                        n_ovalid = 1'b1;
                        n_flush  = r_flush - 1'b1;
                        if (r_flush == RADIUS_BITS'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_radius <= '0;
            r_sum    <= '0;
            r_wp     <= '0;
            r_seen   <= '0;
            r_flush  <= '0;
            r_ovalid <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_radius <= n_radius;
            r_sum    <= n_sum;
            r_wp     <= n_wp;
            r_seen   <= n_seen;
            r_flush  <= n_flush;
            r_ovalid <= n_ovalid;
            r_last   <= n_last;
        end
        r_raddr <= n_raddr;
        r_avg   <= n_avg;
        r_olast <= n_olast;
    end

    cma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wp),
        .i_wdata (sample),
        .i_re    (ram_re),
        .i_raddr (r_raddr),
        .o_rdata (ram_rdata)
    );

    cma_div #(
        .DVD_W (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_plus),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = ODW'(r_avg);
    assign o_m_axis_tlast  = r_olast;

endmodule

[verif/tb_centered_moving_average.sv]
// Testbench for the centered moving average filter against a window-sum predictor.
module tb_centered_moving_average;
    import cma_pkg::*;

    localparam int SAMPLE_W       = DEF_SAMPLE_BITS;
    localparam int IN_W           = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_W          = ((SAMPLE_W + 8) / 8) * 8;
    localparam int AVG_W          = SAMPLE_W + 1;
    localparam int STORE_D        = 128;
    localparam int SETTLE_CYCLES  = 64;    // lets the divider settle once the queues drain
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 6000;

    localparam logic [AVG_W-1:0]    INCOMPLETE_AVG = '1;   // -1: window runs past an end
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                is_last;
    } t_sample_word;

    typedef struct packed {
        logic [AVG_W-1:0] average;
        logic             last_result;
    } t_avg_result;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [RADIUS_BITS-1:0] i_cfg_wdata     = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_W-1:0]        i_s_axis_tdata  = '0;   // sample
    logic                   i_s_axis_tlast  = 1'b0; // is_last
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]       o_m_axis_tdata;         // average
    logic                   o_m_axis_tlast;         // last_result

    centered_moving_average DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Words waiting to be offered, and averages waiting to come out.
    t_sample_word sample_backlog [$];
    t_avg_result  avg_expected [$];

    // Predictor copy of the filter state.
    logic [SAMPLE_W-1:0]    window_copy [STORE_D];
    logic [22:0]            sum_copy    = '0;
    logic [6:0]             wptr_copy   = '0;
    logic [6:0]             seen_copy   = '0;
    logic [RADIUS_BITS-1:0] radius_copy = '0;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int words_queued    = 0;
    int words_accepted  = 0;
    int results_seen    = 0;
    int full_windows    = 0;
    int sequences_ended = 0;
    int fault_count     = 0;
    int quiet_cycles    = 0;
    int hold_count      = 0;
    logic hold_armed    = 1'b0;
    logic word_taken    = 1'b0;

    // Advance the predictor by one accepted sample; push every average it yields.
    task automatic predict_window(input logic [SAMPLE_W-1:0] smp, input logic lst);
        int k;
        int two_k;
        int centre;
        int flush;
        int produced;
        t_avg_result r;
        begin
            k = radius_copy;
            if (k > DEF_MAX_RADIUS) k = DEF_MAX_RADIUS;
            two_k = 2 * k;
            centre = seen_copy;
            produced = 0;
            r.last_result = 1'b0;
            window_copy[wptr_copy] = smp;
            sum_copy = sum_copy + smp;
            if (centre >= two_k) begin
                // window complete: truncated mean, then drop the oldest sample
                r.average = AVG_W'(int'(sum_copy) / (two_k + 1));
                avg_expected.push_back(r);
                produced++;
                full_windows++;
                sum_copy = sum_copy - window_copy[7'(int'(wptr_copy) - two_k)];
            end else if (centre >= k) begin
                r.average = INCOMPLETE_AVG;
                avg_expected.push_back(r);
                produced++;
            end
            if (seen_copy < two_k) seen_copy++;
            wptr_copy = wptr_copy + 7'd1;
            if (lst) begin
                // flush the trailing centres, mark the final one, restart
                flush = (centre + 1 < k) ? centre + 1 : k;
                for (int j = 0; j < flush; j++) begin
                    r.average = INCOMPLETE_AVG;
                    avg_expected.push_back(r);
                    produced++;
                end
                if (produced > 0) begin
                    r = avg_expected.pop_back();
                    r.last_result = 1'b1;
                    avg_expected.push_back(r);
                end
                sequences_ended++;
                sum_copy  = '0;
                seen_copy = '0;
                wptr_copy = '0;
            end
        end
    endtask

    // Record input handshakes and feed the predictor.
    always @(posedge i_clk) begin
        word_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            predict_window(i_s_axis_tdata[SAMPLE_W-1:0], i_s_axis_tlast);
            words_accepted++;
        end
    end

    // Sender: offer the next pending word once the current one is gone.
    always @(negedge i_clk) begin
        t_sample_word next_word;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || word_taken) begin
            if (sample_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_word = sample_backlog.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= IN_W'(next_word.sample);
                i_s_axis_tlast  <= next_word.is_last;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold so the filter backs up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_armed && hold_count < HOLD_CYCLES) begin
            i_m_axis_tready <= 1'b0;
            hold_count++;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each output word with the oldest expected average.
    always @(posedge i_clk) begin
        t_avg_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (avg_expected.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected word, expected none, actual tdata=%h tlast=%b",
                         $time, o_m_axis_tdata, o_m_axis_tlast);
            end else begin
                want = avg_expected.pop_front();
                if (o_m_axis_tdata !== OUT_W'(want.average)) begin
                    fault_count++;
                    $display("%0t: average mismatch, expected %h actual %h",
                             $time, OUT_W'(want.average), o_m_axis_tdata);
                end
                if (o_m_axis_tlast !== want.last_result) begin
                    fault_count++;
                    $display("%0t: last flag mismatch, expected %b actual %b",
                             $time, want.last_result, o_m_axis_tlast);
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles, %0d averages pending",
                     $time, quiet_cycles, avg_expected.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return SAMPLE_MAX;
            default: return SAMPLE_W'($urandom_range(SAMPLE_MAX));
        endcase
    endfunction

    task automatic queue_word(input logic [SAMPLE_W-1:0] smp, input logic lst);
        t_sample_word w;
        begin
            w.sample  = smp;
            w.is_last = lst;
            sample_backlog.push_back(w);
            words_queued++;
        end
    endtask

    task automatic queue_sequence(input int len, input logic terminated, input logic all_max);
        for (int i = 0; i < len; i++)
            queue_word(all_max ? SAMPLE_MAX : pick_sample(), terminated && (i == len - 1));
    endtask

    // Hold until every word is taken and every average is out, then let the
    // filter settle.
    task automatic wait_drained();
        while (words_accepted != words_queued || avg_expected.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the radius while idle; any write restarts the open sequence.
    task automatic write_radius(input logic [RADIUS_BITS-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        radius_copy = value;
        sum_copy    = '0;
        seen_copy   = '0;
        wptr_copy   = '0;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One random phase: mostly whole sequences, sometimes an open one cut short by the next write.
    task automatic run_phase(input logic [RADIUS_BITS-1:0] radius, input int target,
                             input int ramp_len);
        int k;
        int len;
        int left;
        begin
            write_radius(radius);
            k = radius;
            if (ramp_len > 0) queue_sequence(ramp_len, 1'b1, 1'b1);
            left = target;
            while (left > 0) begin
                if ($urandom_range(9) < 7) len = $urandom_range(3 * k + 3, 1);
                else                       len = $urandom_range(k + 1, 1);
                if (len > left) len = left;
                queue_sequence(len, 1'b1, 1'b0);
                left -= len;
            end
            if ($urandom_range(1)) queue_sequence($urandom_range(k + 2, 1), 1'b0, 1'b0);
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles 29 percent of the time, receiver 80 percent.
        send_idle_pct = 29;
        recv_idle_pct = 80;

        // Radius zero: every sample is its own average; extremes of the sample.
        write_radius(0);
        queue_word('0, 1'b0);
        queue_word(SAMPLE_MAX, 1'b1);
        queue_word(16'h5A5A, 1'b0);
        queue_word(16'hA5A5, 1'b1);

        // Radius one: full windows of max values, one-sample and two-sample sequences.
        write_radius(1);
        queue_word(SAMPLE_MAX, 1'b0);
        queue_word(SAMPLE_MAX, 1'b0);
        queue_word(SAMPLE_MAX, 1'b0);
        queue_word(16'd1, 1'b0);
        queue_word('0, 1'b1);
        queue_word(16'd7, 1'b1);
        queue_word(SAMPLE_MAX, 1'b0);
        queue_word('0, 1'b1);

        // Largest radius: sequences shorter than k flush only incomplete windows.
        write_radius(63);
        queue_word(16'd1, 1'b0);
        queue_word(16'd2, 1'b0);
        queue_word(16'd3, 1'b1);
        queue_word(16'h8000, 1'b1);

        // Open sequence, then a radius write mid-sequence restarts it.
        write_radius(2);
        queue_word(16'h1234, 1'b0);
        queue_word(16'hFEDC, 1'b0);
        queue_word(16'h0F0F, 1'b0);

        run_phase(3, 40, 0);
        // Full-scale window: the sum reaches its widest value.
        run_phase(63, 20, 130);

        // Receiver idles 29 percent of the time, sender 80 percent.
        send_idle_pct = 80;
        recv_idle_pct = 29;
        run_phase(5, 40, 0);
        run_phase(0, 40, 0);

        // No idling; the long receiver hold lands while the previous phase drains.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed <= 1'b1;
        run_phase(RADIUS_BITS'($urandom_range(63)), 40, 0);
        run_phase(1, 40, 0);

        wait_drained();
        $display("Run covered %0d sample words in %0d closed sequences, radii 0 to 63.",
                 words_accepted, sequences_ended);
        $display("Checked %0d averages, %0d from complete windows.", results_seen, full_windows);
        if (fault_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/cma_pkg.sv
rtl/core/cma_ram.sv
rtl/core/cma_div.sv
rtl/core/centered_moving_average.sv
verif/tb_centered_moving_average.sv
